// File: hw/rtl/blsw_pkg.sv
`timescale 1ns / 1ps

package blsw_pkg;

	localparam int LINE_W = 24;
	localparam int OFFSET_W = 32;

	localparam logic [1:0] KIND_BRACKET = 2'd0;
	localparam logic [1:0] KIND_STRING  = 2'd1;
	localparam logic [1:0] KIND_WORD    = 2'd2;
	localparam logic [1:0] KIND_EOF     = 2'd3;

	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_VTAB      = 8'h0B;
	localparam logic [7:0] CH_FFEED     = 8'h0C;
	localparam logic [7:0] CH_CRET      = 8'h0D;

	typedef struct packed {
		logic [7:0] char_value;
		logic       end_of_input;
		logic       mode;
	} lex_in_t;

	typedef struct packed {
		logic [7:0]          token_byte;
		logic                has_byte;
		logic                token_first;
		logic                token_last;
		logic [1:0]          token_kind;
		logic                unterminated;
		logic [LINE_W-1:0]   start_line;
		logic [OFFSET_W-1:0] start_offset;
		logic                item_done;
	} lex_out_t;

	typedef struct packed {
		logic [1:0] count;
		lex_out_t   first_res;
		lex_out_t   second_res;
	} step_res_t;

endpackage

// File: hw/rtl/blsw_step.sv
`timescale 1ns / 1ps

module blsw_step #(
	parameter int LINE_BITS = 24,
	parameter int OFFSET_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  blsw_pkg::lex_in_t  item,
	input  logic               commit,
	output blsw_pkg::step_res_t res
);

	localparam logic [2:0] ST_SKIP    = 3'd0;
	localparam logic [2:0] ST_COMMENT = 3'd1;
	localparam logic [2:0] ST_STRING  = 3'd2;
	localparam logic [2:0] ST_ESCAPE  = 3'd3;
	localparam logic [2:0] ST_WORD    = 3'd4;

	logic [2:0]             scan_q;
	logic [2:0]             scan_d;
	logic [LINE_BITS-1:0]   line_q;
	logic [LINE_BITS-1:0]   line_n;
	logic [OFFSET_BITS-1:0] byte_q;
	logic [OFFSET_BITS-1:0] byte_n;
	logic [LINE_BITS-1:0]   open_line_q;
	logic [OFFSET_BITS-1:0] open_offset_q;
	logic                   open_now;

	logic [63:0] line_n_w;
	logic [63:0] line_q_w;
	logic [63:0] open_line_w;
	logic [63:0] byte_n_w;
	logic [63:0] byte_q_w;
	logic [63:0] open_offset_w;

	logic [7:0] c;
	logic       c_space;
	logic       c_bracket;
	logic       word_end;

	blsw_pkg::lex_out_t skip_res;
	logic               skip_emit;
	logic [2:0]         skip_state;

	function automatic blsw_pkg::lex_out_t make_res(
		input logic [7:0]                    b,
		input logic                          has,
		input logic                          first,
		input logic                          last,
		input logic [1:0]                    kind,
		input logic                          unterm,
		input logic [blsw_pkg::LINE_W-1:0]   line,
		input logic [blsw_pkg::OFFSET_W-1:0] off
	);
		blsw_pkg::lex_out_t r;
		r.token_byte   = b;
		r.has_byte     = has;
		r.token_first  = first;
		r.token_last   = last;
		r.token_kind   = kind;
		r.unterminated = unterm;
		r.start_line   = line;
		r.start_offset = off;
		r.item_done    = 1'b0;
		return r;
	endfunction

	assign c = item.char_value;
	assign c_space = (c == blsw_pkg::CH_SPACE) || (c == blsw_pkg::CH_TAB) ||
		(c == blsw_pkg::CH_NEWLINE) || (c == blsw_pkg::CH_VTAB) ||
		(c == blsw_pkg::CH_FFEED) || (c == blsw_pkg::CH_CRET);
	assign c_bracket = (c == blsw_pkg::CH_LBRACKET) || (c == blsw_pkg::CH_RBRACKET) ||
		(c == blsw_pkg::CH_LBRACE) || (c == blsw_pkg::CH_RBRACE);
	assign word_end = c_space || (c == blsw_pkg::CH_HASH) || (c == blsw_pkg::CH_QUOTE) ||
		(!item.mode && c_bracket);

	assign line_n = ((c == blsw_pkg::CH_NEWLINE) && (line_q != {LINE_BITS{1'b1}})) ?
		line_q + LINE_BITS'(1) : line_q;
	assign byte_n = (byte_q != {OFFSET_BITS{1'b1}}) ? byte_q + OFFSET_BITS'(1) : byte_q;

	assign line_n_w      = 64'(line_n);
	assign line_q_w      = 64'(line_q);
	assign open_line_w   = 64'(open_line_q);
	assign byte_n_w      = 64'(byte_n);
	assign byte_q_w      = 64'(byte_q);
	assign open_offset_w = 64'(open_offset_q);

	always_comb begin
		skip_emit = 1'b0;
		skip_state = ST_SKIP;
		skip_res = make_res(c, 1'b1, 1'b1, 1'b0, blsw_pkg::KIND_WORD, 1'b0,
			line_n_w[blsw_pkg::LINE_W-1:0], byte_n_w[blsw_pkg::OFFSET_W-1:0]);
		priority if (c_space) begin
			skip_state = ST_SKIP;
		end else if (c == blsw_pkg::CH_HASH) begin
			skip_state = ST_COMMENT;
		end else if (c_bracket) begin
			skip_emit = 1'b1;
			skip_res.token_last = 1'b1;
			skip_res.token_kind = blsw_pkg::KIND_BRACKET;
		end else if (c == blsw_pkg::CH_QUOTE) begin
			skip_emit = 1'b1;
			skip_state = ST_STRING;
			skip_res.token_kind = blsw_pkg::KIND_STRING;
		end else begin
			skip_emit = 1'b1;
			skip_state = ST_WORD;
		end
	end

	always_comb begin
		res.count = 2'd0;
		res.first_res = make_res(c, 1'b1, 1'b0, 1'b0, blsw_pkg::KIND_STRING, 1'b0,
			open_line_w[blsw_pkg::LINE_W-1:0], open_offset_w[blsw_pkg::OFFSET_W-1:0]);
		res.second_res = skip_res;
		scan_d = scan_q;
		open_now = 1'b0;
		if (item.end_of_input) begin
			res.second_res = make_res(8'd0, 1'b0, 1'b1, 1'b1, blsw_pkg::KIND_EOF, 1'b0,
				line_q_w[blsw_pkg::LINE_W-1:0], byte_q_w[blsw_pkg::OFFSET_W-1:0]);
			res.first_res.token_byte = 8'd0;
			res.first_res.has_byte = 1'b0;
			res.first_res.token_last = 1'b1;
			scan_d = ST_SKIP;
			if ((scan_q == ST_STRING) || (scan_q == ST_ESCAPE)) begin
				res.first_res.unterminated = 1'b1;
				res.count = 2'd2;
			end else if (scan_q == ST_WORD) begin
				res.first_res.token_kind = blsw_pkg::KIND_WORD;
				res.count = 2'd2;
			end else begin
				res.first_res = res.second_res;
				res.count = 2'd1;
			end
		end else begin
			unique case (scan_q)
				ST_COMMENT: begin
					if ((c == blsw_pkg::CH_NEWLINE) || (c == blsw_pkg::CH_HASH)) begin
						scan_d = ST_SKIP;
					end
				end
				ST_ESCAPE: begin
					res.count = 2'd1;
					scan_d = ST_STRING;
				end
				ST_STRING: begin
					priority if (c == blsw_pkg::CH_QUOTE) begin
						res.first_res.token_last = 1'b1;
						res.count = 2'd1;
						scan_d = ST_SKIP;
					end else if (c == blsw_pkg::CH_BACKSLASH) begin
						scan_d = ST_ESCAPE;
					end else begin
						res.count = 2'd1;
					end
				end
				ST_WORD: begin
					res.first_res.token_kind = blsw_pkg::KIND_WORD;
					if (word_end) begin
						res.first_res.token_byte = 8'd0;
						res.first_res.has_byte = 1'b0;
						res.first_res.token_last = 1'b1;
						res.count = skip_emit ? 2'd2 : 2'd1;
						scan_d = skip_state;
						open_now = 1'b1;
					end else begin
						res.count = 2'd1;
					end
				end
				default: begin
					res.first_res = skip_res;
					res.count = skip_emit ? 2'd1 : 2'd0;
					scan_d = skip_state;
					open_now = 1'b1;
				end
			endcase
		end
		if (res.count == 2'd1) begin
			res.first_res.item_done = 1'b1;
		end
		if (res.count == 2'd2) begin
			res.second_res.item_done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= ST_SKIP;
			line_q <= LINE_BITS'(1);
			byte_q <= '0;
			open_line_q <= LINE_BITS'(1);
			open_offset_q <= '0;
		end else if (commit) begin
			scan_q <= scan_d;
			if (!item.end_of_input) begin
				line_q <= line_n;
				byte_q <= byte_n;
				if (open_now && ((skip_state == ST_STRING) || (skip_state == ST_WORD))) begin
					open_line_q <= line_n;
					open_offset_q <= byte_n;
				end
			end
		end
	end

endmodule

// File: hw/rtl/bracket_string_word_lexer_core.sv
`timescale 1ns / 1ps
// A byte request is registered at acceptance, and its first token result, if any, is
// loaded from that input register into the output register when the output can take it.
// Throughput is one byte per cycle while the output does not stall; a byte that closes
// a word and opens a token, or an end of input closing an open token, holds the input
// register until both results load: the single output register takes one per cycle.
// Reset clears the handshake state, the scanner to whitespace skipping, the line to 1
// and the byte offset to 0.

module bracket_string_word_lexer_core #(
	parameter int LINE_BITS = 24,
	parameter int OFFSET_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  blsw_pkg::lex_in_t  byte_data,
	output logic               token_valid,
	input  logic               token_stall,
	output blsw_pkg::lex_out_t token_data
);

	logic                valid_s1;
	blsw_pkg::lex_in_t   item_s1;
	logic                phase_q;
	logic                out_valid_q;
	blsw_pkg::lex_out_t  out_q;
	blsw_pkg::step_res_t step_res;
	logic                can_load;
	logic                consume;
	logic                load_out;

	blsw_step #(
		.LINE_BITS(LINE_BITS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_s1),
		.commit(consume),
		.res(step_res)
	);

	assign can_load = !out_valid_q || !token_stall;
	assign consume = valid_s1 && ((step_res.count == 2'd0) ||
		(can_load && (phase_q || (step_res.count == 2'd1))));
	assign load_out = valid_s1 && (step_res.count != 2'd0) && can_load;
	assign byte_stall = valid_s1 && !consume;

	assign token_valid = out_valid_q;
	assign token_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!byte_stall) begin
				valid_s1 <= byte_valid;
			end
			if (consume) begin
				phase_q <= 1'b0;
			end else if (load_out) begin
				phase_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!token_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
		if (load_out) begin
			out_q <= phase_q ? step_res.second_res : step_res.first_res;
		end
	end

endmodule

// File: hw/rtl/blsw_checker.sv
`timescale 1ns / 1ps

module blsw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               token_valid,
	input logic               token_stall,
	input blsw_pkg::lex_out_t token_data
);

	a_token_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid)
		else $error("token request dropped while stalled");

	a_token_stable: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> $stable(token_data))
		else $error("token request changed while stalled");

	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_data.token_kind == blsw_pkg::KIND_EOF) |->
		token_data.token_first && token_data.token_last && token_data.item_done &&
		!token_data.has_byte)
		else $error("malformed end-of-file result");

	a_empty_closes: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_data.has_byte |-> token_data.token_last)
		else $error("result without a byte does not close a token");

	a_unterm_string: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_data.unterminated |->
		(token_data.token_kind == blsw_pkg::KIND_STRING) && !token_data.has_byte)
		else $error("unterminated flag on a result that is not a cut string");

endmodule

bind bracket_string_word_lexer_core blsw_checker u_blsw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.token_valid(token_valid),
	.token_stall(token_stall),
	.token_data(token_data)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int RAND_ITEMS = 1325;
	localparam int QUIET_FIRST = 600;
	localparam int QUIET_LAST = 850;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 160;
	localparam int CYCLE_LIMIT = 200000;

	typedef logic [blsw_pkg::LINE_W-1:0] line_t;
	typedef logic [blsw_pkg::OFFSET_W-1:0] off_t;

	typedef enum logic [2:0] {
		SC_SKIP,
		SC_COMMENT,
		SC_STRING,
		SC_ESCAPE,
		SC_WORD
	} scan_t;

	typedef struct packed {
		blsw_pkg::lex_in_t  req;
		logic               typed;
		blsw_pkg::lex_out_t want;
	} lex_row_t;

	logic clk;
	logic arst_n;
	logic byte_valid;
	logic byte_stall;
	blsw_pkg::lex_in_t byte_data;
	logic token_valid;
	logic token_stall;
	blsw_pkg::lex_out_t token_data;

	scan_t scan_st;
	line_t line_cnt;
	off_t  byte_cnt;
	line_t open_line;
	off_t  open_off;

	blsw_pkg::lex_out_t step_buf[$];
	blsw_pkg::lex_out_t tok_exp[$];
	lex_row_t dir_rows[$];

	logic quiet;
	int bytes_taken;
	int tokens_seen = 0;
	int eof_seen = 0;
	int errors = 0;
	int cycles = 0;
	int hold_left;
	logic held;

	bracket_string_word_lexer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_data(token_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic blsw_pkg::lex_out_t tok(
		input logic [7:0] b,
		input logic       has,
		input logic       first,
		input logic       last,
		input logic [1:0] kind,
		input logic       unterm,
		input line_t      line,
		input off_t       off
	);
		blsw_pkg::lex_out_t t;
		t.token_byte = b;
		t.has_byte = has;
		t.token_first = first;
		t.token_last = last;
		t.token_kind = kind;
		t.unterminated = unterm;
		t.start_line = line;
		t.start_offset = off;
		t.item_done = 1'b0;
		return t;
	endfunction

	function automatic lex_row_t row(input logic [7:0] c, input logic eoi, input logic md);
		lex_row_t r;
		r.req.char_value = c;
		r.req.end_of_input = eoi;
		r.req.mode = md;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// Each typed row causes a single result, which also ends its request.
	function automatic lex_row_t row_typed(input logic [7:0] c, input logic eoi,
			input logic md, input blsw_pkg::lex_out_t want);
		lex_row_t r;
		r = row(c, eoi, md);
		r.typed = 1'b1;
		r.want = want;
		r.want.item_done = 1'b1;
		return r;
	endfunction

	function automatic logic is_brk(input logic [7:0] c);
		return c == blsw_pkg::CH_LBRACKET || c == blsw_pkg::CH_RBRACKET ||
			c == blsw_pkg::CH_LBRACE || c == blsw_pkg::CH_RBRACE;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c == blsw_pkg::CH_SPACE || c == blsw_pkg::CH_TAB ||
			c == blsw_pkg::CH_NEWLINE || c == blsw_pkg::CH_VTAB ||
			c == blsw_pkg::CH_FFEED || c == blsw_pkg::CH_CRET;
	endfunction

	function automatic void open_token();
		open_line = line_cnt;
		open_off = byte_cnt;
	endfunction

	function automatic void start_token(input logic [7:0] c);
		if (is_blank(c)) begin
			scan_st = SC_SKIP;
		end else if (c == blsw_pkg::CH_HASH) begin
			scan_st = SC_COMMENT;
		end else if (is_brk(c)) begin
			scan_st = SC_SKIP;
			step_buf.push_back(tok(c, 1'b1, 1'b1, 1'b1, blsw_pkg::KIND_BRACKET, 1'b0,
				line_cnt, byte_cnt));
		end else if (c == blsw_pkg::CH_QUOTE) begin
			open_token();
			scan_st = SC_STRING;
			step_buf.push_back(tok(c, 1'b1, 1'b1, 1'b0, blsw_pkg::KIND_STRING, 1'b0,
				open_line, open_off));
		end else begin
			open_token();
			scan_st = SC_WORD;
			step_buf.push_back(tok(c, 1'b1, 1'b1, 1'b0, blsw_pkg::KIND_WORD, 1'b0,
				open_line, open_off));
		end
	endfunction

	function automatic void lex_step(input blsw_pkg::lex_in_t r);
		logic [7:0] c;
		c = r.char_value;
		step_buf.delete();
		if (r.end_of_input) begin
			if (scan_st == SC_STRING || scan_st == SC_ESCAPE)
				step_buf.push_back(tok(8'h00, 1'b0, 1'b0, 1'b1, blsw_pkg::KIND_STRING, 1'b1,
					open_line, open_off));
			else if (scan_st == SC_WORD)
				step_buf.push_back(tok(8'h00, 1'b0, 1'b0, 1'b1, blsw_pkg::KIND_WORD, 1'b0,
					open_line, open_off));
			step_buf.push_back(tok(8'h00, 1'b0, 1'b1, 1'b1, blsw_pkg::KIND_EOF, 1'b0,
				line_cnt, byte_cnt));
			scan_st = SC_SKIP;
		end else begin
			if (byte_cnt != '1)
				byte_cnt = byte_cnt + 1'b1;
			if (c == blsw_pkg::CH_NEWLINE && line_cnt != '1)
				line_cnt = line_cnt + 1'b1;
			case (scan_st)
				SC_COMMENT: begin
					if (c == blsw_pkg::CH_NEWLINE || c == blsw_pkg::CH_HASH)
						scan_st = SC_SKIP;
				end
				SC_ESCAPE: begin
					step_buf.push_back(tok(c, 1'b1, 1'b0, 1'b0, blsw_pkg::KIND_STRING, 1'b0,
						open_line, open_off));
					scan_st = SC_STRING;
				end
				SC_STRING: begin
					if (c == blsw_pkg::CH_QUOTE) begin
						step_buf.push_back(tok(c, 1'b1, 1'b0, 1'b1, blsw_pkg::KIND_STRING,
							1'b0, open_line, open_off));
						scan_st = SC_SKIP;
					end else if (c == blsw_pkg::CH_BACKSLASH) begin
						scan_st = SC_ESCAPE;
					end else begin
						step_buf.push_back(tok(c, 1'b1, 1'b0, 1'b0, blsw_pkg::KIND_STRING,
							1'b0, open_line, open_off));
					end
				end
				SC_WORD: begin
					if ((!r.mode && is_brk(c)) || is_blank(c) ||
							(c == blsw_pkg::CH_HASH) || (c == blsw_pkg::CH_QUOTE)) begin
						step_buf.push_back(tok(8'h00, 1'b0, 1'b0, 1'b1, blsw_pkg::KIND_WORD,
							1'b0, open_line, open_off));
						start_token(c);
					end else begin
						step_buf.push_back(tok(c, 1'b1, 1'b0, 1'b0, blsw_pkg::KIND_WORD,
							1'b0, open_line, open_off));
					end
				end
				default: start_token(c);
			endcase
		end
		if (step_buf.size() > 0)
			step_buf[step_buf.size() - 1].item_done = 1'b1;
		foreach (step_buf[i])
			tok_exp.push_back(step_buf[i]);
	endfunction

	function automatic string fmt_res(input blsw_pkg::lex_out_t t);
		string s;
		s = {$sformatf("byte %h has %b first %b last %b kind %0d ", t.token_byte,
				t.has_byte, t.token_first, t.token_last, t.token_kind),
			$sformatf("unterm %b line %0d off %0d done %b", t.unterminated,
				t.start_line, t.start_offset, t.item_done)};
		return s;
	endfunction

	function automatic logic [7:0] pick_char();
		int unsigned k;
		logic [7:0] blanks [6];
		logic [7:0] brks [4];
		blanks = '{blsw_pkg::CH_SPACE, blsw_pkg::CH_TAB, blsw_pkg::CH_NEWLINE,
			blsw_pkg::CH_VTAB, blsw_pkg::CH_FFEED, blsw_pkg::CH_CRET};
		brks = '{blsw_pkg::CH_LBRACKET, blsw_pkg::CH_RBRACKET, blsw_pkg::CH_LBRACE,
			blsw_pkg::CH_RBRACE};
		k = $urandom_range(99);
		if (k < 30)
			return 8'($urandom_range(255));
		else if (k < 46)
			return 8'($urandom_range(122, 97));
		else if (k < 56)
			return blanks[3'($urandom_range(5))];
		else if (k < 67)
			return brks[2'($urandom_range(3))];
		else if (k < 75)
			return blsw_pkg::CH_QUOTE;
		else if (k < 80)
			return blsw_pkg::CH_BACKSLASH;
		else if (k < 86)
			return blsw_pkg::CH_HASH;
		else
			return blsw_pkg::CH_NEWLINE;
	endfunction

	task automatic offer_byte(input blsw_pkg::lex_in_t r);
		while (!quiet && $urandom_range(99) < 18) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= r;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_taken++;
		lex_step(r);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles > CYCLE_LIMIT);
		$display("Run exceeded %0d cycles with %0d results still due.", CYCLE_LIMIT,
			tok_exp.size());
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		blsw_pkg::lex_out_t want;
		if (arst_n && token_valid && !token_stall) begin
			tokens_seen++;
			if (token_data.token_kind == blsw_pkg::KIND_EOF)
				eof_seen++;
			if (tok_exp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected token result %h at cycle %0d", token_data, cycles);
			end else begin
				want = tok_exp.pop_front();
				if (token_data !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("Mismatch at cycle %0d:", cycles);
						$display("  expected %s", fmt_res(want));
						$display("  got      %s", fmt_res(token_data));
					end
				end
			end
		end
	end

	initial begin
		token_stall <= 1'b0;
		hold_left = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				token_stall <= 1'b1;
				hold_left--;
			end else if (!held && bytes_taken >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				token_stall <= 1'b1;
			end else begin
				token_stall <= !quiet && ($urandom_range(99) < 18);
			end
		end
	end

	initial begin
		blsw_pkg::lex_in_t r;
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_data <= '0;
		quiet = 1'b0;
		bytes_taken = 0;
		scan_st = SC_SKIP;
		line_cnt = line_t'(1);
		byte_cnt = '0;
		open_line = line_t'(1);
		open_off = '0;

		dir_rows.push_back(row_typed(8'h00, 1'b1, 1'b0, tok(8'h00, 1'b0, 1'b1, 1'b1,
			blsw_pkg::KIND_EOF, 1'b0, line_t'(1), off_t'(0))));
		dir_rows.push_back(row_typed(blsw_pkg::CH_LBRACKET, 1'b0, 1'b0,
			tok(blsw_pkg::CH_LBRACKET, 1'b1, 1'b1, 1'b1, blsw_pkg::KIND_BRACKET, 1'b0,
			line_t'(1), off_t'(1))));
		dir_rows.push_back(row_typed(blsw_pkg::CH_RBRACE, 1'b0, 1'b1,
			tok(blsw_pkg::CH_RBRACE, 1'b1, 1'b1, 1'b1, blsw_pkg::KIND_BRACKET, 1'b0,
			line_t'(1), off_t'(2))));
		dir_rows.push_back(row("a", 1'b0, 1'b0));
		dir_rows.push_back(row(8'hFF, 1'b0, 1'b1));
		dir_rows.push_back(row(blsw_pkg::CH_LBRACE, 1'b0, 1'b1));
		dir_rows.push_back(row(blsw_pkg::CH_RBRACKET, 1'b0, 1'b0));
		dir_rows.push_back(row("b", 1'b0, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_QUOTE, 1'b0, 1'b0));
		dir_rows.push_back(row("x", 1'b0, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_BACKSLASH, 1'b0, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_QUOTE, 1'b0, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_BACKSLASH, 1'b0, 1'b1));
		dir_rows.push_back(row(8'hA5, 1'b1, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_HASH, 1'b0, 1'b0));
		dir_rows.push_back(row("z", 1'b0, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_HASH, 1'b0, 1'b0));
		dir_rows.push_back(row(8'h00, 1'b0, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_NEWLINE, 1'b0, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_HASH, 1'b0, 1'b1));
		dir_rows.push_back(row(blsw_pkg::CH_NEWLINE, 1'b0, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_QUOTE, 1'b0, 1'b0));
		dir_rows.push_back(row(blsw_pkg::CH_QUOTE, 1'b0, 1'b0));
		dir_rows.push_back(row("q", 1'b0, 1'b1));
		dir_rows.push_back(row(8'h5A, 1'b1, 1'b1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			offer_byte(dir_rows[i].req);
			if (dir_rows[i].typed) begin
				void'(tok_exp.pop_back());
				tok_exp.push_back(dir_rows[i].want);
			end
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
			r.char_value = pick_char();
			r.end_of_input = ($urandom_range(99) < 3);
			r.mode = 1'($urandom_range(1));
			offer_byte(r);
		end
		quiet = 1'b0;
		byte_valid <= 1'b0;

		while (tok_exp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Lexed %0d bytes and end markers into %0d results, %0d of them end of file.",
			bytes_taken, tokens_seen, eof_seen);
		$display("Input and output stalls were random, with one quiet stretch and one long hold.");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/blsw_pkg.sv
hw/rtl/blsw_step.sv
hw/rtl/bracket_string_word_lexer_core.sv
hw/rtl/blsw_checker.sv
tb/testbench.sv
